FILE: rtl/hcpf_pkg.sv
// Shared widths, register indexes and pipeline payload types of the contact force pipeline.
package hcpf_pkg;

   localparam int ID_W       = 16;
   localparam int POS_W      = 32;
   localparam int LEN_W      = 31;
   localparam int DIFF_W     = 33;
   localparam int MAG_W      = 32;
   localparam int SQ_W       = 64;
   localparam int ROOT_STEPS = 32;
   localparam int ROOT_REM_W = 34;
   localparam int DIV_STEPS  = 32;
   localparam int CSR_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int AXES       = 3;

   localparam logic [MAG_W-1:0] NEG_LIMIT = 32'h8000_0000;
   localparam logic [MAG_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STIFFNESS = 2'd0,
      CSR_BOX_X     = 2'd1,
      CSR_BOX_Y     = 2'd2,
      CSR_BOX_Z     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } sep_type;

   typedef struct packed {
      logic              neg;
      logic [DIFF_W-1:0] rest;
      logic [LEN_W-1:0]  rem;
      logic [POS_W-1:0]  raw;
   } wrap_type;

   typedef struct packed {
      logic [SQ_W-1:0]       rest;
      logic [ROOT_REM_W-1:0] rem;
      logic [MAG_W-1:0]      root;
   } root_type;

   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [MAG_W-1:0] quot;
   } div_type;

   typedef struct packed {
      logic [ID_W-1:0]        first_index;
      logic [ID_W-1:0]        second_index;
      logic [MAG_W-1:0]       rsum;
      sep_type [AXES-1:0]     sep;
      logic                   hit;
      logic [MAG_W-1:0]       ov;
      logic [MAG_W-1:0]       rij;
      logic [MAG_W-1:0]       mag;
      logic                   contact;
   } pipe_type;

endpackage

FILE: rtl/hertz_contact_pair_force.sv
// Fully pipelined Hertzian contact force between one particle pair in a periodic box.
// One transaction is accepted every cycle while busy is low.
// Each periodic wrap, square root and final division consumes one or two input bits
// per stage, and the length of these restoring chains sets the latency.
// Synchronous reset empties the pipeline and loads the register defaults; busy is high
// during reset and until the registered busy flag clears after it. Results cannot be held off by the receiver.
module hertz_contact_pair_force #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [hcpf_pkg::ID_W-1:0]         req_first_index,
   input  logic [hcpf_pkg::ID_W-1:0]         req_second_index,
   input  logic signed [hcpf_pkg::POS_W-1:0] req_first_pos_x,
   input  logic signed [hcpf_pkg::POS_W-1:0] req_first_pos_y,
   input  logic signed [hcpf_pkg::POS_W-1:0] req_first_pos_z,
   input  logic signed [hcpf_pkg::POS_W-1:0] req_second_pos_x,
   input  logic signed [hcpf_pkg::POS_W-1:0] req_second_pos_y,
   input  logic signed [hcpf_pkg::POS_W-1:0] req_second_pos_z,
   input  logic [hcpf_pkg::LEN_W-1:0]        req_first_radius,
   input  logic [hcpf_pkg::LEN_W-1:0]        req_second_radius,
   input  logic                              csr_write_enable,
   input  logic [hcpf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hcpf_pkg::CSR_W-1:0]        csr_write_data,
   output logic                              rsp_strobe,
   output logic [hcpf_pkg::ID_W-1:0]         rsp_out_first_index,
   output logic [hcpf_pkg::ID_W-1:0]         rsp_out_second_index,
   output logic                              rsp_in_contact,
   output logic signed [hcpf_pkg::MAG_W-1:0] rsp_force_x,
   output logic signed [hcpf_pkg::MAG_W-1:0] rsp_force_y,
   output logic signed [hcpf_pkg::MAG_W-1:0] rsp_force_z
);

   localparam int F        = FRACTION_BITS;
   localparam int OVR_IN_W = 32 + F + ((32 + F) % 2);
   localparam int S_W      = OVR_IN_W / 2;
   localparam int P_W      = 32 + S_W - F;
   localparam int P_HI_W   = P_W - 32;
   localparam int PROD_W   = 64 + P_HI_W;
   localparam int M5_W     = PROD_W + 3;

   localparam logic [hcpf_pkg::CSR_W-1:0] K_RESET   = 32'(((1 << F) + 5) / 10);
   localparam logic [hcpf_pkg::LEN_W-1:0] BOX_RESET = 31'(5 << F);

   localparam int WRAP_STEPS = hcpf_pkg::DIFF_W;
   localparam int ST_SEP     = WRAP_STEPS + 1;
   localparam int ST_SQ      = ST_SEP + 1;
   localparam int ST_ROOT0   = ST_SQ + 1;
   localparam int ST_OV      = ST_ROOT0 + hcpf_pkg::ROOT_STEPS + 1;
   localparam int ST_POW     = ST_OV + S_W + 1;
   localparam int ST_KPART   = ST_POW + 1;
   localparam int ST_KSUM    = ST_KPART + 1;
   localparam int ST_MAG     = ST_KSUM + 1;
   localparam int ST_NUM     = ST_MAG + 1;
   localparam int ST_OUT     = ST_NUM + hcpf_pkg::DIV_STEPS + 1;
   localparam int LATENCY    = ST_OUT + 1;

   typedef struct packed {
      logic [OVR_IN_W-1:0] rest;
      logic [S_W+1:0]      rem;
      logic [S_W-1:0]      root;
   } ovr_type;

   logic                          busy_ff;
   logic                          accept;
   logic [hcpf_pkg::CSR_W-1:0]    stiffness_ff, stiffness_in;
   logic [hcpf_pkg::LEN_W-1:0]    box_ff [hcpf_pkg::AXES];
   logic [hcpf_pkg::LEN_W-1:0]    box_in [hcpf_pkg::AXES];

   logic                          valid_ff [LATENCY];
   logic                          valid_in [LATENCY];
   hcpf_pkg::pipe_type            pipe_ff  [LATENCY];
   hcpf_pkg::pipe_type            pipe_in  [LATENCY];

   hcpf_pkg::wrap_type [hcpf_pkg::AXES-1:0] wrap_ff [WRAP_STEPS+1];
   hcpf_pkg::wrap_type [hcpf_pkg::AXES-1:0] wrap_in [WRAP_STEPS+1];
   hcpf_pkg::sep_type  [hcpf_pkg::AXES-1:0] sep_next;

   logic [hcpf_pkg::SQ_W-1:0]     sq_ff [hcpf_pkg::AXES];
   logic [hcpf_pkg::SQ_W-1:0]     sq_in [hcpf_pkg::AXES];
   hcpf_pkg::root_type            root_ff [hcpf_pkg::ROOT_STEPS+1];
   hcpf_pkg::root_type            root_in [hcpf_pkg::ROOT_STEPS+1];

   logic [hcpf_pkg::MAG_W-1:0]    rij_value;
   logic [hcpf_pkg::MAG_W-1:0]    ov_value;
   logic                          hit_value;
   ovr_type                       ovr_ff [S_W+1];
   ovr_type                       ovr_in [S_W+1];

   logic [32+S_W-1:0]             pow_full;
   logic [P_W-1:0]                pow_ff, pow_in;
   logic [63:0]                   kp_lo_ff, kp_lo_in;
   logic [32+P_HI_W-1:0]          kp_hi_ff, kp_hi_in;
   logic [PROD_W-1:0]             kprod_ff, kprod_in;
   logic [M5_W-1:0]               m5;
   logic                          mag_cap;
   logic [hcpf_pkg::MAG_W-1:0]    mag_value;

   hcpf_pkg::div_type [hcpf_pkg::AXES-1:0] div_ff [hcpf_pkg::DIV_STEPS+1];
   hcpf_pkg::div_type [hcpf_pkg::AXES-1:0] div_in [hcpf_pkg::DIV_STEPS+1];

   logic [hcpf_pkg::MAG_W-1:0]    force_ff [hcpf_pkg::AXES];
   logic [hcpf_pkg::MAG_W-1:0]    force_in [hcpf_pkg::AXES];

   logic [hcpf_pkg::POS_W-1:0]    pos_a [hcpf_pkg::AXES];
   logic [hcpf_pkg::POS_W-1:0]    pos_b [hcpf_pkg::AXES];

   assign busy   = busy_ff | reset;
   assign accept = start & ~busy;

   assign pos_a[0] = req_first_pos_x;
   assign pos_a[1] = req_first_pos_y;
   assign pos_a[2] = req_first_pos_z;
   assign pos_b[0] = req_second_pos_x;
   assign pos_b[1] = req_second_pos_y;
   assign pos_b[2] = req_second_pos_z;

   always_comb begin
      stiffness_in = stiffness_ff;
      box_in       = box_ff;
      if (csr_write_enable) begin
         unique case (hcpf_pkg::csr_index_type'(csr_index))
            hcpf_pkg::CSR_STIFFNESS: begin
               stiffness_in = csr_write_data;
            end
            hcpf_pkg::CSR_BOX_X: begin
               box_in[0] = csr_write_data[hcpf_pkg::LEN_W-1:0];
            end
            hcpf_pkg::CSR_BOX_Y: begin
               box_in[1] = csr_write_data[hcpf_pkg::LEN_W-1:0];
            end
            hcpf_pkg::CSR_BOX_Z: begin
               box_in[2] = csr_write_data[hcpf_pkg::LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Entry stage and the restoring remainder steps of the periodic wrap.
   always_comb begin
      logic [hcpf_pkg::DIFF_W-1:0] diff_pos;
      logic [hcpf_pkg::DIFF_W-1:0] diff_neg;
      logic [hcpf_pkg::LEN_W:0]    wrap_t;
      for (int k = 0; k < hcpf_pkg::AXES; k++) begin
         diff_pos = {pos_a[k][hcpf_pkg::POS_W-1], pos_a[k]}
                  - {pos_b[k][hcpf_pkg::POS_W-1], pos_b[k]};
         diff_neg = {pos_b[k][hcpf_pkg::POS_W-1], pos_b[k]}
                  - {pos_a[k][hcpf_pkg::POS_W-1], pos_a[k]};
         wrap_in[0][k].neg  = diff_pos[hcpf_pkg::DIFF_W-1];
         wrap_in[0][k].rest = diff_pos[hcpf_pkg::DIFF_W-1] ? diff_neg : diff_pos;
         wrap_in[0][k].rem  = '0;
         wrap_in[0][k].raw  = diff_pos[hcpf_pkg::POS_W-1:0];
      end
      for (int j = 1; j <= WRAP_STEPS; j++) begin
         for (int k = 0; k < hcpf_pkg::AXES; k++) begin
            wrap_t = {wrap_ff[j-1][k].rem, wrap_ff[j-1][k].rest[hcpf_pkg::DIFF_W-1]};
            wrap_in[j][k].neg  = wrap_ff[j-1][k].neg;
            wrap_in[j][k].raw  = wrap_ff[j-1][k].raw;
            wrap_in[j][k].rest = wrap_ff[j-1][k].rest << 1;
            if (wrap_t >= {1'b0, box_ff[k]}) begin
               wrap_in[j][k].rem = hcpf_pkg::LEN_W'(wrap_t - {1'b0, box_ff[k]});
            end else begin
               wrap_in[j][k].rem = wrap_t[hcpf_pkg::LEN_W-1:0];
            end
         end
      end
   end

   // Nearest image as sign and size: remainder or its complement to the box length; raw difference if box is zero.
   always_comb begin
      hcpf_pkg::wrap_type w;
      for (int k = 0; k < hcpf_pkg::AXES; k++) begin
         w = wrap_ff[WRAP_STEPS][k];
         if (box_ff[k] == '0) begin
            sep_next[k].neg = w.raw[hcpf_pkg::POS_W-1];
            sep_next[k].mag = w.raw[hcpf_pkg::POS_W-1] ? (32'd0 - w.raw) : w.raw;
         end else if ({w.rem, 1'b0} >= {1'b0, box_ff[k]}) begin
            sep_next[k].neg = ~w.neg;
            sep_next[k].mag = {1'b0, box_ff[k]} - {1'b0, w.rem};
         end else begin
            sep_next[k].neg = w.neg;
            sep_next[k].mag = {1'b0, w.rem};
         end
      end
   end

   // Squares, their sum and its square root, the centre distance.
   always_comb begin
      logic [hcpf_pkg::ROOT_REM_W:0] cur;
      logic [hcpf_pkg::ROOT_REM_W:0] trial;
      for (int k = 0; k < hcpf_pkg::AXES; k++) begin
         sq_in[k] = pipe_ff[ST_SQ-1].sep[k].mag * pipe_ff[ST_SQ-1].sep[k].mag;
      end
      root_in[0].rest = sq_ff[0] + sq_ff[1] + sq_ff[2];
      root_in[0].rem  = '0;
      root_in[0].root = '0;
      for (int j = 1; j <= hcpf_pkg::ROOT_STEPS; j++) begin
         cur   = {root_ff[j-1].rem[hcpf_pkg::ROOT_REM_W-2:0],
                  root_ff[j-1].rest[hcpf_pkg::SQ_W-1 -: 2]};
         trial = {1'b0, root_ff[j-1].root, 2'b01};
         root_in[j].rest = root_ff[j-1].rest << 2;
         if (cur >= trial) begin
            root_in[j].rem  = hcpf_pkg::ROOT_REM_W'(cur - trial);
            root_in[j].root = {root_ff[j-1].root[hcpf_pkg::MAG_W-2:0], 1'b1};
         end else begin
            root_in[j].rem  = hcpf_pkg::ROOT_REM_W'(cur);
            root_in[j].root = {root_ff[j-1].root[hcpf_pkg::MAG_W-2:0], 1'b0};
         end
      end
   end

   // Overlap and the square root of the overlap.
   always_comb begin
      logic [S_W+2:0] cur;
      logic [S_W+2:0] trial;
      rij_value = root_ff[hcpf_pkg::ROOT_STEPS].root;
      hit_value = (pipe_ff[ST_OV-1].rsum > rij_value) && (rij_value != '0);
      ov_value  = pipe_ff[ST_OV-1].rsum - rij_value;
      ovr_in[0].rest = OVR_IN_W'({ov_value, {F{1'b0}}});
      ovr_in[0].rem  = '0;
      ovr_in[0].root = '0;
      for (int j = 1; j <= S_W; j++) begin
         cur   = {ovr_ff[j-1].rem[S_W:0], ovr_ff[j-1].rest[OVR_IN_W-1 -: 2]};
         trial = {1'b0, ovr_ff[j-1].root, 2'b01};
         ovr_in[j].rest = ovr_ff[j-1].rest << 2;
         if (cur >= trial) begin
            ovr_in[j].rem  = (S_W+2)'(cur - trial);
            ovr_in[j].root = {ovr_ff[j-1].root[S_W-2:0], 1'b1};
         end else begin
            ovr_in[j].rem  = (S_W+2)'(cur);
            ovr_in[j].root = {ovr_ff[j-1].root[S_W-2:0], 1'b0};
         end
      end
   end

   // Overlap to the power 1.5 and the scaled magnitude 2.5 * K * P.
   always_comb begin
      pow_full = pipe_ff[ST_POW-1].ov * ovr_ff[S_W].root;
      pow_in   = pow_full[F +: P_W];
      kp_lo_in = stiffness_ff * pow_ff[31:0];
      kp_hi_in = stiffness_ff * pow_ff[P_W-1:32];
      kprod_in = PROD_W'(kp_lo_ff) + {kp_hi_ff, 32'd0};
      m5       = M5_W'(kprod_ff) + M5_W'({kprod_ff, 2'b00});
      mag_cap  = |m5[M5_W-1:F+33];
      mag_value = mag_cap ? '1 : m5[F+1 +: hcpf_pkg::MAG_W];
   end

   // Component numerators and restoring division by the centre distance.
   always_comb begin
      logic [63:0]               num;
      logic [hcpf_pkg::MAG_W:0]  div_t;
      logic [hcpf_pkg::MAG_W-1:0] rij;
      for (int k = 0; k < hcpf_pkg::AXES; k++) begin
         num = pipe_ff[ST_NUM-1].mag * pipe_ff[ST_NUM-1].sep[k].mag;
         div_in[0][k].rem  = num[63:32];
         div_in[0][k].quot = num[31:0];
      end
      for (int j = 1; j <= hcpf_pkg::DIV_STEPS; j++) begin
         rij = pipe_ff[ST_NUM+j-1].rij;
         for (int k = 0; k < hcpf_pkg::AXES; k++) begin
            div_t = {div_ff[j-1][k].rem, div_ff[j-1][k].quot[hcpf_pkg::MAG_W-1]};
            if (div_t >= {1'b0, rij}) begin
               div_in[j][k].rem  = hcpf_pkg::MAG_W'(div_t - {1'b0, rij});
               div_in[j][k].quot = {div_ff[j-1][k].quot[hcpf_pkg::MAG_W-2:0], 1'b1};
            end else begin
               div_in[j][k].rem  = div_t[hcpf_pkg::MAG_W-1:0];
               div_in[j][k].quot = {div_ff[j-1][k].quot[hcpf_pkg::MAG_W-2:0], 1'b0};
            end
         end
      end
   end

   // Signed saturation of each component, zero without contact.
   always_comb begin
      logic [hcpf_pkg::MAG_W-1:0] c;
      for (int k = 0; k < hcpf_pkg::AXES; k++) begin
         c = div_ff[hcpf_pkg::DIV_STEPS][k].quot;
         if (!pipe_ff[ST_OUT-1].contact) begin
            force_in[k] = '0;
         end else if (pipe_ff[ST_OUT-1].sep[k].neg) begin
            force_in[k] = 32'd0 - ((c > hcpf_pkg::NEG_LIMIT) ? hcpf_pkg::NEG_LIMIT : c);
         end else begin
            force_in[k] = (c > hcpf_pkg::POS_LIMIT) ? hcpf_pkg::POS_LIMIT : c;
         end
      end
   end

   always_comb begin
      pipe_in[0]              = '0;
      pipe_in[0].first_index  = req_first_index;
      pipe_in[0].second_index = req_second_index;
      pipe_in[0].rsum         = 32'(req_first_radius) + 32'(req_second_radius);
      valid_in[0]             = accept;
      for (int i = 1; i < LATENCY; i++) begin
         pipe_in[i]  = pipe_ff[i-1];
         valid_in[i] = valid_ff[i-1];
         if (i == ST_SEP) begin
            pipe_in[i].sep = sep_next;
         end
         if (i == ST_OV) begin
            pipe_in[i].hit = hit_value;
            pipe_in[i].ov  = ov_value;
            pipe_in[i].rij = rij_value;
         end
         if (i == ST_MAG) begin
            pipe_in[i].mag     = mag_value;
            pipe_in[i].contact = pipe_ff[i-1].hit & (|mag_value);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         stiffness_ff <= K_RESET;
         for (int k = 0; k < hcpf_pkg::AXES; k++) begin
            box_ff[k] <= BOX_RESET;
         end
         for (int i = 0; i < LATENCY; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         busy_ff      <= 1'b0;
         stiffness_ff <= stiffness_in;
         box_ff       <= box_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pipe_ff  <= pipe_in;
      wrap_ff  <= wrap_in;
      sq_ff    <= sq_in;
      root_ff  <= root_in;
      ovr_ff   <= ovr_in;
      pow_ff   <= pow_in;
      kp_lo_ff <= kp_lo_in;
      kp_hi_ff <= kp_hi_in;
      kprod_ff <= kprod_in;
      div_ff   <= div_in;
      force_ff <= force_in;
   end

   assign rsp_strobe           = valid_ff[ST_OUT];
   assign rsp_out_first_index  = pipe_ff[ST_OUT].first_index;
   assign rsp_out_second_index = pipe_ff[ST_OUT].second_index;
   assign rsp_in_contact       = pipe_ff[ST_OUT].contact;
   assign rsp_force_x          = force_ff[0];
   assign rsp_force_y          = force_ff[1];
   assign rsp_force_z          = force_ff[2];

endmodule

FILE: rtl/hcpf_checker.sv
// Port-level checks of the contact force pipeline and their binding to the top level.
module hcpf_checker #(
   parameter int LATENCY = 132
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic [hcpf_pkg::ID_W-1:0]         req_first_index,
   input logic [hcpf_pkg::ID_W-1:0]         req_second_index,
   input logic                              rsp_strobe,
   input logic [hcpf_pkg::ID_W-1:0]         rsp_out_first_index,
   input logic [hcpf_pkg::ID_W-1:0]         rsp_out_second_index,
   input logic                              rsp_in_contact,
   input logic signed [hcpf_pkg::MAG_W-1:0] rsp_force_x,
   input logic signed [hcpf_pkg::MAG_W-1:0] rsp_force_y,
   input logic signed [hcpf_pkg::MAG_W-1:0] rsp_force_z
);

   // Every accepted transaction yields a result strobe.
   a_accept_to_strobe: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("accepted transaction produced no result");

   a_strobe_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without an accepted transaction");

   a_index_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_out_first_index == $past(req_first_index, LATENCY))
                  && (rsp_out_second_index == $past(req_second_index, LATENCY)))
      else $error("particle indices not carried with their transaction");

   a_no_contact_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_in_contact) |->
         (rsp_force_x == '0) && (rsp_force_y == '0) && (rsp_force_z == '0))
      else $error("nonzero force reported without contact");

endmodule

bind hertz_contact_pair_force hcpf_checker #(.LATENCY(LATENCY)) u_hcpf_checker (
   .clock                (clock),
   .reset                (reset),
   .start                (start),
   .busy                 (busy),
   .req_first_index      (req_first_index),
   .req_second_index     (req_second_index),
   .rsp_strobe           (rsp_strobe),
   .rsp_out_first_index  (rsp_out_first_index),
   .rsp_out_second_index (rsp_out_second_index),
   .rsp_in_contact       (rsp_in_contact),
   .rsp_force_x          (rsp_force_x),
   .rsp_force_y          (rsp_force_y),
   .rsp_force_z          (rsp_force_z)
);
